>>> design/bounded_ordered_list_unit_assert.svh
// assertion macros for the bounded ordered list unit
`ifndef BOUNDED_ORDERED_LIST_UNIT_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BOLU_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BOLU_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BOLU_ASSERT_IMPL(label, prop, msg)
`define BOLU_ASSERT_NEVER(label, expr, msg)
`endif
`endif

>>> design/bolu_pkg.sv
// shared constants and types of the bounded ordered list unit
`default_nettype none
package bolu_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 4;
    localparam int CMD_W    = 3;
    localparam int LETTER_W = 8;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [CNT_W-1:0]    fill_t;

    localparam cmd_t CMD_APPEND       = 3'd0;
    localparam cmd_t CMD_INSERT_HEAD  = 3'd1;
    localparam cmd_t CMD_REMOVE_TAIL  = 3'd2;
    localparam cmd_t CMD_REMOVE_HEAD  = 3'd3;
    localparam cmd_t CMD_REMOVE_MATCH = 3'd4;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_ctl_t;

endpackage
`default_nettype wire

>>> design/bolu_ctrl.sv
// controller state machine of the bounded ordered list unit
`default_nettype none
module bolu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output bolu_pkg::dp_ctl_t      ctl
);
    import bolu_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign ctl.load = start && (state_reg == S_IDLE);
    assign ctl.exec = (state_reg == S_EXEC);

endmodule
`default_nettype wire

>>> design/bolu_datapath.sv
// entry cells, fill count and result registers of the bounded ordered list unit
`default_nettype none
module bolu_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bolu_pkg::dp_ctl_t             ctl,
    input  wire logic [bolu_pkg::CMD_W-1:0]    command,
    input  wire logic [bolu_pkg::LETTER_W-1:0] letter,
    output logic                               ok,
    output logic [bolu_pkg::COUNT_W-1:0]       count,
    output logic                               is_full,
    output logic                               is_empty
);
    import bolu_pkg::*;

    cmd_t    cmd_reg;
    letter_t letter_reg;
    letter_t entries_reg [CAPACITY];
    letter_t entries_next [CAPACITY];
    letter_t above [CAPACITY];
    letter_t below [CAPACITY];
    fill_t   fill_reg;
    fill_t   fill_next;
    logic    ok_reg;
    logic    ok_next;
    logic    full_reg;
    logic    empty_reg;
    logic    full_now;
    logic    empty_now;
    logic    found;
    logic    seen;
    logic [CAPACITY-1:0] hit;
    logic [CAPACITY-1:0] tail_mask;

    assign full_now  = (fill_reg == CNT_W'(CAPACITY));
    assign empty_now = (fill_reg == '0);

    // neighbor taps of each cell
    always_comb
    begin
        below[0]            = letter_reg;
        above[CAPACITY-1]   = entries_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            below[i]   = entries_reg[i-1];
            above[i-1] = entries_reg[i];
        end
    end

    // parallel match, cells from the first hit upward close the gap
    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit[i]       = (CNT_W'(i) < fill_reg) && (entries_reg[i] == letter_reg);
            seen         = seen | hit[i];
            tail_mask[i] = seen;
        end
        found = seen;
    end

    always_comb
    begin
        fill_next = fill_reg;
        ok_next   = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (!full_now)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CNT_W'(i) == fill_reg)
                        begin
                            entries_next[i] = letter_reg;
                        end
                    end
                    fill_next = fill_reg + 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_INSERT_HEAD:
            begin
                if (!full_now)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        entries_next[i] = below[i];
                    end
                    fill_next = fill_reg + 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_REMOVE_TAIL:
            begin
                if (!empty_now)
                begin
                    fill_next = fill_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_REMOVE_HEAD:
            begin
                if (!empty_now)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        entries_next[i] = above[i];
                    end
                    fill_next = fill_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            CMD_REMOVE_MATCH:
            begin
                if (found)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (tail_mask[i])
                        begin
                            entries_next[i] = above[i];
                        end
                    end
                    fill_next = fill_reg - 1'b1;
                    ok_next   = 1'b1;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctl.exec)
        begin
            fill_reg <= fill_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= command;
            letter_reg <= letter;
        end
        if (ctl.exec)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                entries_reg[i] <= entries_next[i];
            end
            ok_reg    <= ok_next;
            full_reg  <= (fill_next == CNT_W'(CAPACITY));
            empty_reg <= (fill_next == '0);
        end
    end

    assign ok       = ok_reg;
    assign count    = COUNT_W'(fill_reg);
    assign is_full  = full_reg;
    assign is_empty = empty_reg;

endmodule
`default_nettype wire

>>> design/bounded_ordered_list_unit.sv
// top level of the bounded ordered list unit
//
// holds up to CAPACITY bytes in order, head at position zero
// command channel: a word (command, letter) is taken at a rising edge
// with start high and busy low
// commands: append at tail, insert at head, remove tail, remove head,
// remove first entry equal to letter; unused codes change nothing
// result channel: done is high for exactly one cycle with ok, count,
// is_full and is_empty valid in that same cycle
// the accepting edge moves the controller from idle into execute; done and
// the results are registered at the end of execute, back in idle
// a new word is not taken while busy; the controller holds busy for
// the single execute cycle in which all cells shift or match in parallel
// busy is low again in the done cycle, so start may be taken there
// the receiver cannot stall: a result is gone after its done cycle
// reset clears the fill count and the controller; entry cells are
// not cleared and are never read before being written
`default_nettype none
`include "bounded_ordered_list_unit_assert.svh"
module bounded_ordered_list_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bolu_pkg::CMD_W-1:0]    command,
    input  wire logic [bolu_pkg::LETTER_W-1:0] letter,
    output logic                               done,
    output logic                               ok,
    output logic [bolu_pkg::COUNT_W-1:0]       count,
    output logic                               is_full,
    output logic                               is_empty
);
    import bolu_pkg::*;

    dp_ctl_t ctl;

    bolu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    bolu_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .command  (command),
        .letter   (letter),
        .ok       (ok),
        .count    (count),
        .is_full  (is_full),
        .is_empty (is_empty)
    );

    `BOLU_ASSERT_IMPL(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
    `BOLU_ASSERT_IMPL(a_busy_done, busy |=> done, "execute cycle not followed by done")
    `BOLU_ASSERT_NEVER(a_done_busy, done && busy, "done while busy")
    `BOLU_ASSERT_NEVER(a_full_empty, done && is_full && is_empty, "full and empty together")

endmodule
`default_nettype wire
